/* rtl/sprite_animation_sequencer_top_assert.svh */
// Assertion macros used by the sprite animation sequencer port checker.
`ifndef SPRITE_ANIMATION_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPRANIM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPRANIM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spranim_pkg.sv */
// Shared types, widths and codes of the sprite animation sequencer.
package spranim_pkg;

    localparam int NUM_STATES = 16;
    localparam int MAX_FRAMES = 256;
    localparam int TIME_BITS  = 32;

    localparam int REQ_W     = 3;
    localparam int STATE_W   = 4;
    localparam int FRAME_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int DIM_W     = 12;
    localparam int CLIPX_W   = 20;
    localparam int CLIPY_W   = 16;
    localparam int ENTRY_W   = COUNT_W + TIME_BITS;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    // Output beat layout, lowest bit first.
    localparam int OUT_CLIPX_LSB  = 0;
    localparam int OUT_CLIPY_LSB  = OUT_CLIPX_LSB + CLIPX_W;
    localparam int OUT_FRAME_LSB  = OUT_CLIPY_LSB + CLIPY_W;
    localparam int OUT_STATE_LSB  = OUT_FRAME_LSB + FRAME_W;
    localparam int OUT_QUEUED_BIT = OUT_STATE_LSB + STATE_W;
    localparam int OUT_ENDED_BIT  = OUT_QUEUED_BIT + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_STATE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_KEEP   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUEUE      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_FRAME  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LOAD       = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_AFTER    = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [TIME_BITS-1:0] elapsed_time;
        logic [STATE_W-1:0]   target_state;
        logic [FRAME_W-1:0]   target_frame;
        logic [COUNT_W-1:0]   entry_frame_count;
        logic [TIME_BITS-1:0] entry_frame_period;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [STATE_W-1:0] state_index;
        logic               state_queued;
        logic               anim_ended;
    } res_t;

endpackage

/* rtl/spranim_ram.sv */
// Generic single-port RAM with registered read data.
module spranim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/spranim_div.sv */
// Restoring divider, one quotient bit per cycle.
module spranim_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [spranim_pkg::TIME_BITS-1:0]    dividend,
    input  logic [spranim_pkg::TIME_BITS-1:0]    divisor,
    output logic                                 done,
    output logic [spranim_pkg::TIME_BITS-1:0]    quot,
    output logic [spranim_pkg::TIME_BITS-1:0]    rem
);
    import spranim_pkg::*;

    localparam int STEP_W = $clog2(TIME_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TIME_BITS-1:0]  q_reg, q_next;
    logic [TIME_BITS-1:0]  r_reg, r_next;
    logic [TIME_BITS-1:0]  d_reg, d_next;
    logic [TIME_BITS:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[TIME_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(TIME_BITS);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and try the subtraction.
            if (trial >= {1'b0, d_reg})
            begin
                r_next = TIME_BITS'(trial - {1'b0, d_reg});
                q_next = {q_reg[TIME_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[TIME_BITS-1:0];
                q_next = {q_reg[TIME_BITS-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

/* rtl/spranim_core.sv */
// Sequencer core: table RAM, animation state and the tick state machine.
module spranim_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spranim_pkg::req_t   req,
    input  logic                end_after_last,
    output logic                res_valid,
    input  logic                res_ready,
    output spranim_pkg::res_t   res
);
    import spranim_pkg::*;

    localparam int ADDR_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_MODF  = 8'b0000_0100,
        ST_CHECK = 8'b0000_1000,
        ST_DIVN  = 8'b0001_0000,
        ST_WRAP  = 8'b0010_0000,
        ST_MODN  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } core_state_t;

    core_state_t          st_reg, st_next;
    logic [STATE_W-1:0]   cur_state_reg, cur_state_next;
    logic [FRAME_W-1:0]   cur_frame_reg, cur_frame_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [STATE_W-1:0]   pend_state_reg, pend_state_next;
    logic                 ended_reg, ended_next;

    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] per_reg, per_next;
    logic [TIME_BITS-1:0] prod_reg, prod_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [COUNT_W-1:0]   rd_count;
    logic [TIME_BITS-1:0] rd_period;
    logic [COUNT_W-1:0]   eff_count;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_dividend;
    logic [TIME_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_quot;
    logic [TIME_BITS-1:0] div_rem;

    logic [TIME_BITS:0]   time_sum;
    logic [COUNT_W-1:0]   to_wrap;
    logic                 take_wrap;
    logic [ENTRY_W-1:0]   wrap_prod;
    logic [COUNT_W:0]     frame_sum;
    logic                 accept;

    spranim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_STATES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    spranim_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign req_ready = (st_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    assign ram_we    = accept && (req.req_type == REQ_LOAD);
    assign ram_wdata = {req.entry_frame_count, req.entry_frame_period};
    assign rd_count  = ram_rdata[ENTRY_W-1:TIME_BITS];
    assign rd_period = ram_rdata[TIME_BITS-1:0];

    // Point the table at the entry the next cycle needs.
    always_comb
    begin
        if (st_reg == ST_WRAP)
        begin
            ram_addr = ADDR_W'(pend_state_reg);
        end
        else if (ram_we)
        begin
            ram_addr = ADDR_W'(req.target_state);
        end
        else
        begin
            ram_addr = ADDR_W'(cur_state_reg);
        end
    end

    // Zero count acts as one; counts above the limit clamp.
    always_comb
    begin
        if (rd_count == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (rd_count > COUNT_W'(MAX_FRAMES))
        begin
            eff_count = COUNT_W'(MAX_FRAMES);
        end
        else
        begin
            eff_count = rd_count;
        end
    end

    assign time_sum  = {1'b0, time_reg} + {1'b0, req.elapsed_time};
    assign to_wrap   = cnt_reg - {1'b0, cur_frame_reg};
    assign take_wrap = pend_valid_reg && ({(TIME_BITS - COUNT_W)'(0), to_wrap} <= div_quot);
    assign wrap_prod = ENTRY_W'(to_wrap) * ENTRY_W'(per_reg);
    assign frame_sum = {2'b00, cur_frame_reg} + {1'b0, div_rem[COUNT_W-1:0]};

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = time_reg - TIME_BITS'(1);
        div_divisor  = per_reg;
        case (st_reg)
            ST_READ:
            begin
                div_start    = 1'b1;
                div_dividend = TIME_BITS'(cur_frame_reg);
                div_divisor  = TIME_BITS'(eff_count);
            end
            ST_CHECK:
            begin
                div_start = (per_reg != '0) && (time_reg > per_reg);
            end
            ST_DIVN:
            begin
                div_start    = div_done && !take_wrap;
                div_dividend = div_quot;
                div_divisor  = TIME_BITS'(cnt_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        st_next         = st_reg;
        cur_state_next  = cur_state_reg;
        cur_frame_next  = cur_frame_reg;
        time_next       = time_reg;
        pend_valid_next = pend_valid_reg;
        pend_state_next = pend_state_reg;
        ended_next      = ended_reg;
        cnt_next        = cnt_reg;
        per_next        = per_reg;
        prod_next       = prod_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = ST_DONE;
                    case (req.req_type)
                        REQ_TICK:
                        begin
                            time_next = time_sum[TIME_BITS] ? TIME_MAX
                                                            : time_sum[TIME_BITS-1:0];
                            st_next   = ST_READ;
                        end
                        REQ_SET_STATE:
                        begin
                            if (req.target_state != cur_state_reg)
                            begin
                                time_next      = '0;
                                cur_frame_next = '0;
                            end
                            cur_state_next = req.target_state;
                        end
                        REQ_SET_KEEP:
                        begin
                            cur_state_next = req.target_state;
                        end
                        REQ_QUEUE:
                        begin
                            pend_valid_next = 1'b1;
                            pend_state_next = req.target_state;
                        end
                        REQ_SET_FRAME:
                        begin
                            cur_frame_next = req.target_frame;
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cnt_next = eff_count;
                per_next = rd_period;
                st_next  = ST_MODF;
            end
            ST_MODF:
            begin
                if (div_done)
                begin
                    cur_frame_next = div_rem[FRAME_W-1:0];
                    st_next        = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                st_next = div_start ? ST_DIVN : ST_DONE;
            end
            ST_DIVN:
            begin
                if (div_done)
                begin
                    if (take_wrap)
                    begin
                        prod_next = wrap_prod[TIME_BITS-1:0];
                        st_next   = ST_WRAP;
                    end
                    else
                    begin
                        time_next = div_rem + TIME_BITS'(1);
                        st_next   = ST_MODN;
                    end
                end
            end
            ST_WRAP:
            begin
                // Switch to the queued state and rerun with its entry.
                time_next       = time_reg - prod_reg;
                cur_frame_next  = '0;
                pend_valid_next = 1'b0;
                cur_state_next  = pend_state_reg;
                ended_next      = ended_reg || end_after_last;
                st_next         = ST_READ;
            end
            ST_MODN:
            begin
                if (div_done)
                begin
                    if (frame_sum >= {1'b0, cnt_reg})
                    begin
                        cur_frame_next = FRAME_W'(frame_sum - {1'b0, cnt_reg});
                    end
                    else
                    begin
                        cur_frame_next = frame_sum[FRAME_W-1:0];
                    end
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            cur_state_reg  <= '0;
            cur_frame_reg  <= '0;
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_state_reg <= '0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            cur_state_reg  <= cur_state_next;
            cur_frame_reg  <= cur_frame_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            pend_state_reg <= pend_state_next;
            ended_reg      <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        per_reg  <= per_next;
        prod_reg <= prod_next;
    end

    assign res_valid        = (st_reg == ST_DONE);
    assign res.frame_index  = cur_frame_reg;
    assign res.state_index  = cur_state_reg;
    assign res.state_queued = pend_valid_reg;
    assign res.anim_ended   = ended_reg;

endmodule

/* rtl/sprite_animation_sequencer_top.sv */
// Sprite animation sequencer: frame and state tracking for a sprite sheet.
//
// The block keeps one table entry per animation state (frame count, frame
// period in unsigned Q16.16) and the current state, frame and time spent in
// that frame. Each input beat is one command, selected by s_axis_tuser:
// tick, set state, set state keeping frame and time, queue a state, set the
// frame, or load a table entry. Every input beat returns exactly one output
// beat with the sheet clip position, the frame, the state, the queued flag
// and the sticky ended flag, all as they stand after the command. Commands
// run one at a time. A non-tick command skips the divider and goes
// straight to its output beat. A tick always reduces the frame modulo
// the count; when frames advance it also counts whole periods and wraps
// the frame, and a queued state switch reruns these with the new entry:
// the time budget and the frame advance go through one shared divider
// that resolves one quotient bit per cycle, used for the frame reduction,
// the whole-period count and the wrap of the frame. The table sits in a
// 16-entry RAM with registered read data; it needs no clearing after
// reset; a tick on a never-loaded state gives undefined results. A new
// command is accepted as soon as the result of the previous one is in the
// output register, even while that beat still waits for m_axis_tready.
// Configuration registers (frame width, frame height, end-after-last) are
// written through the cfg channel, which is always ready; write them only
// while no command is in flight.
module sprite_animation_sequencer_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input command beats.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // elapsed_time[31:0], target_state[35:32], target_frame[43:36],
    // entry_frame_count[52:44], entry_frame_period[84:53], zeros[87:85]
    input  logic [spranim_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type[2:0]
    input  logic [spranim_pkg::REQ_W-1:0]         s_axis_tuser,
    // Result beats.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // clip_x[19:0], clip_y[35:20], frame_index[43:36], state_index[47:44],
    // state_queued[48], anim_ended[49], zeros[55:50]
    output logic [spranim_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spranim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spranim_pkg::DIM_W-1:0]         cfg_data
);
    import spranim_pkg::*;

    logic [DIM_W-1:0]      frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]      frame_height_reg, frame_height_next;
    logic                  end_after_reg, end_after_next;

    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    req_t                  core_req;
    logic                  core_res_valid;
    logic                  core_res_ready;
    res_t                  core_res;
    logic [CLIPX_W-1:0]    clip_x;
    logic [CLIPY_W-1:0]    clip_y;

    // Configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        end_after_next    = end_after_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
                CFG_END_AFTER:    end_after_next    = cfg_data[0];
                default:          end_after_next    = end_after_reg;
            endcase
        end
    end

    // Unpack the input beat into the command fields.
    assign core_req.req_type           = s_axis_tuser;
    assign core_req.elapsed_time       = s_axis_tdata[31:0];
    assign core_req.target_state       = s_axis_tdata[35:32];
    assign core_req.target_frame       = s_axis_tdata[43:36];
    assign core_req.entry_frame_count  = s_axis_tdata[52:44];
    assign core_req.entry_frame_period = s_axis_tdata[84:53];

    spranim_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (s_axis_tvalid),
        .req_ready      (s_axis_tready),
        .req            (core_req),
        .end_after_last (end_after_reg),
        .res_valid      (core_res_valid),
        .res_ready      (core_res_ready),
        .res            (core_res)
    );

    // Clip offsets into the sheet: column by frame, row by state.
    assign clip_x = CLIPX_W'(core_res.frame_index) * CLIPX_W'(frame_width_reg);
    assign clip_y = CLIPY_W'(core_res.state_index) * CLIPY_W'(frame_height_reg);

    // Load the output register when it is empty or being drained.
    assign core_res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (core_res_valid && core_res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {{(M_TDATA_W - OUT_ENDED_BIT - 1){1'b0}},
                            core_res.anim_ended,
                            core_res.state_queued,
                            core_res.state_index,
                            core_res.frame_index,
                            clip_y,
                            clip_x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(32);
            frame_height_reg <= DIM_W'(32);
            end_after_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            end_after_reg    <= end_after_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* rtl/spranim_chk.sv */
// Port-level checker for the sprite animation sequencer, bound to the top.
`include "sprite_animation_sequencer_top_assert.svh"

module spranim_chk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [spranim_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import spranim_pkg::*;

    // A stalled result beat holds.
    `SPRANIM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // Commands run one at a time: no acceptance right after one.
    `SPRANIM_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted while another is in flight")

    // Once reported, the ended flag stays set for as long as the result stays valid.
    `SPRANIM_ASSERT_NEXT(a_ended_sticky, m_axis_tvalid && m_axis_tdata[OUT_ENDED_BIT], !m_axis_tvalid || m_axis_tdata[OUT_ENDED_BIT], "ended flag cleared")

    // Padding bits of the result beat stay zero.
    `SPRANIM_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:OUT_ENDED_BIT+1] == '0, "result padding not zero")

endmodule

bind sprite_animation_sequencer_top spranim_chk u_spranim_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sprite_animation_sequencer_checker.sv */
// Checker for the sprite animation sequencer: tracks the animation state and scores result beats.
module sprite_animation_sequencer_checker
    import spranim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [REQ_W-1:0]     s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   positions_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_STATE_LSB  = TIME_BITS;
    localparam int IN_FRAME_LSB  = IN_STATE_LSB + STATE_W;
    localparam int IN_COUNT_LSB  = IN_FRAME_LSB + FRAME_W;
    localparam int IN_PERIOD_LSB = IN_COUNT_LSB + COUNT_W;

    typedef struct packed {
        logic [CLIPX_W-1:0] clip_x;
        logic [CLIPY_W-1:0] clip_y;
        logic [FRAME_W-1:0] frame_index;
        logic [STATE_W-1:0] state_index;
        logic               state_queued;
        logic               anim_ended;
    } sprite_pos_t;

    sprite_pos_t predicted_pos_q[$];

    logic [COUNT_W-1:0]   count_mem [NUM_STATES];
    logic [TIME_BITS-1:0] period_mem [NUM_STATES];
    logic [STATE_W-1:0]   anim_state;
    logic [FRAME_W-1:0]   anim_frame;
    logic [TIME_BITS-1:0] anim_time;
    logic                 switch_pending;
    logic [STATE_W-1:0]   switch_target;
    logic                 ended_sticky;
    logic [DIM_W-1:0]     geom_width;
    logic [DIM_W-1:0]     geom_height;
    logic                 end_on_switch;

    // Zero counts act as one, oversized counts clamp to MAX_FRAMES.
    function automatic logic [63:0] frames_in_state(input logic [STATE_W-1:0] st);
        logic [63:0] c;
        c = 64'(count_mem[st]);
        if (c == 64'd0) c = 64'd1;
        if (c > 64'(MAX_FRAMES)) c = 64'(MAX_FRAMES);
        return c;
    endfunction

    function automatic void advance_by_time(input logic [TIME_BITS-1:0] elapsed);
        logic [63:0] sum;
        logic [63:0] per;
        logic [63:0] cnt;
        logic [63:0] steps;
        logic [63:0] to_wrap;
        int round;
        cnt = frames_in_state(anim_state);
        anim_frame = FRAME_W'(64'(anim_frame) % cnt);
        sum = 64'(anim_time) + 64'(elapsed);
        anim_time = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
        // A queued switch can happen once per tick, so two rounds cover it.
        for (round = 0; round < 2; round++) begin
            per = 64'(period_mem[anim_state]);
            cnt = frames_in_state(anim_state);
            if (per == 64'd0 || 64'(anim_time) <= per) return;
            steps = (64'(anim_time) - 64'd1) / per;
            if (switch_pending) begin
                to_wrap = cnt - 64'(anim_frame);
                if (steps >= to_wrap) begin
                    anim_time = TIME_BITS'(64'(anim_time) - to_wrap * per);
                    anim_frame = '0;
                    switch_pending = 1'b0;
                    anim_state = switch_target;
                    if (end_on_switch) ended_sticky = 1'b1;
                    continue;
                end
            end
            anim_time = TIME_BITS'(64'(anim_time) - steps * per);
            anim_frame = FRAME_W'((64'(anim_frame) + steps % cnt) % cnt);
            return;
        end
    endfunction

    function automatic void apply_command(input logic [REQ_W-1:0] req,
                                          input logic [S_TDATA_W-1:0] data);
        logic [STATE_W-1:0] tgt;
        tgt = data[IN_STATE_LSB +: STATE_W];
        case (req)
            REQ_TICK:
                advance_by_time(data[0 +: TIME_BITS]);
            REQ_SET_STATE:
            begin
                if (tgt != anim_state) begin
                    anim_time = '0;
                    anim_frame = '0;
                end
                anim_state = tgt;
            end
            REQ_SET_KEEP:
                anim_state = tgt;
            REQ_QUEUE:
            begin
                switch_pending = 1'b1;
                switch_target = tgt;
            end
            REQ_SET_FRAME:
                anim_frame = data[IN_FRAME_LSB +: FRAME_W];
            REQ_LOAD:
            begin
                count_mem[tgt] = data[IN_COUNT_LSB +: COUNT_W];
                period_mem[tgt] = data[IN_PERIOD_LSB +: TIME_BITS];
            end
            default:
                ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sprite_pos_t want;
        sprite_pos_t got;
        if (!rst_n) begin
            predicted_pos_q.delete();
            foreach (count_mem[i]) begin
                count_mem[i] = '0;
                period_mem[i] = '0;
            end
            anim_state = '0;
            anim_frame = '0;
            anim_time = '0;
            switch_pending = 1'b0;
            switch_target = '0;
            ended_sticky = 1'b0;
            geom_width = DIM_W'(32);
            geom_height = DIM_W'(32);
            end_on_switch = 1'b0;
            mismatch_count = 0;
            positions_owed = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  geom_width = cfg_data;
                    CFG_FRAME_HEIGHT: geom_height = cfg_data;
                    CFG_END_AFTER:    end_on_switch = cfg_data[0];
                    default:          ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.clip_x = m_axis_tdata[OUT_CLIPX_LSB +: CLIPX_W];
                got.clip_y = m_axis_tdata[OUT_CLIPY_LSB +: CLIPY_W];
                got.frame_index = m_axis_tdata[OUT_FRAME_LSB +: FRAME_W];
                got.state_index = m_axis_tdata[OUT_STATE_LSB +: STATE_W];
                got.state_queued = m_axis_tdata[OUT_QUEUED_BIT];
                got.anim_ended = m_axis_tdata[OUT_ENDED_BIT];
                if (predicted_pos_q.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    mismatch_count++;
                end
                else begin
                    want = predicted_pos_q.pop_front();
                    check_field("clip_x", 32'(want.clip_x), 32'(got.clip_x));
                    check_field("clip_y", 32'(want.clip_y), 32'(got.clip_y));
                    check_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
                    check_field("state_index", 32'(want.state_index), 32'(got.state_index));
                    check_field("state_queued", 32'(want.state_queued),
                                32'(got.state_queued));
                    check_field("anim_ended", 32'(want.anim_ended), 32'(got.anim_ended));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_command(s_axis_tuser, s_axis_tdata);
                want.clip_x = CLIPX_W'(32'(anim_frame) * 32'(geom_width));
                want.clip_y = CLIPY_W'(32'(anim_state) * 32'(geom_height));
                want.frame_index = anim_frame;
                want.state_index = anim_state;
                want.state_queued = switch_pending;
                want.anim_ended = ended_sticky;
                predicted_pos_q.push_back(want);
            end
            positions_owed = predicted_pos_q.size();
        end
    end

endmodule

/* tb/tb.sv */
// Top of the sprite animation sequencer testbench: stimulus, backpressure and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spranim_pkg::*;

    // Request codes the block must ignore.
    localparam logic [REQ_W-1:0] REQ_RSVD0 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD1 = 3'd7;
    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 205;
    // Leave margin past the worst tick, one with a queued switch.
    localparam int TAIL_CYCLES     = 256;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [REQ_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    int mismatch_count;
    int positions_owed;

    // Idle percentages of the command sender and the result receiver.
    int src_idle_pct = 34;
    int dst_idle_pct = 53;

    // States whose table entry has been loaded; only these may be ticked.
    logic [NUM_STATES-1:0] loaded = '0;

    sprite_animation_sequencer_top dut (.*);

    sprite_animation_sequencer_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Redraw result backpressure at random on every falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // Give up when no beat of any channel moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Send one command beat. Call on a falling edge; returns on a falling edge.
    // Valid only drops when an idle gap is taken, so it never dips and
    // rises within the same step.
    task automatic send_cmd(input logic [REQ_W-1:0] req, input logic [TIME_BITS-1:0] elapsed,
                            input logic [STATE_W-1:0] tgt, input logic [FRAME_W-1:0] frm,
                            input logic [COUNT_W-1:0] cnt, input logic [TIME_BITS-1:0] per);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tuser <= req;
        s_axis_tdata <= {3'b000, per, cnt, frm, tgt, elapsed};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (req == REQ_LOAD) loaded[tgt] = 1'b1;
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted result beat has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (positions_owed != 0);
    endtask

    // Write every register, the unmapped index too. Only call while idle.
    task automatic write_config(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                                input logic end_flag);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [DIM_W-1:0]     val [4];
        int i;
        idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_END_AFTER, CFG_SPARE};
        // Upper bits of the flag write are junk the block must drop.
        val = '{width, height, {(DIM_W-1)'($urandom), end_flag}, DIM_W'($urandom)};
        cfg_valid <= 1'b1;
        for (i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random command. Every field starts fully random, then the fields that
    // matter for the chosen request are shaped so that frames advance, wrap
    // and queued switches fire, with some extremes mixed in.
    task automatic send_random_cmd();
        logic [REQ_W-1:0]     req;
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS-1:0] per;
        logic [STATE_W-1:0]   tgt;
        logic [FRAME_W-1:0]   frm;
        logic [COUNT_W-1:0]   cnt;
        int roll;
        elapsed = $urandom;
        per = $urandom;
        tgt = STATE_W'($urandom);
        frm = FRAME_W'($urandom);
        cnt = COUNT_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 48) req = REQ_TICK;
        else if (roll < 56) req = REQ_SET_STATE;
        else if (roll < 62) req = REQ_SET_KEEP;
        else if (roll < 72) req = REQ_QUEUE;
        else if (roll < 80) req = REQ_SET_FRAME;
        else if (roll < 96) req = REQ_LOAD;
        else req = $urandom_range(0, 1) ? REQ_RSVD0 : REQ_RSVD1;
        roll = $urandom_range(0, 99);
        case (req)
            REQ_TICK:
            begin
                if (roll < 60) elapsed = $urandom_range(0, 32'h0003_0000);
                else if (roll < 70) elapsed = $urandom_range(0, 32'h0000_0100);
                else if (roll < 80) elapsed = '0;
                else if (roll < 88) elapsed = TIME_MAX;
            end
            REQ_SET_STATE, REQ_SET_KEEP, REQ_QUEUE:
            begin
                // Stay on loaded entries so no tick reads an unwritten one.
                do tgt = STATE_W'($urandom_range(0, NUM_STATES - 1)); while (!loaded[tgt]);
            end
            REQ_SET_FRAME:
            begin
                if (roll < 60) frm = FRAME_W'($urandom_range(0, 12));
            end
            REQ_LOAD:
            begin
                if (roll < 60) per = $urandom_range(32'h0000_4000, 32'h0001_8000);
                else if (roll < 70) per = '0;
                else if (roll < 78) per = $urandom_range(1, 4);
                else if (roll < 84) per = TIME_MAX;
                roll = $urandom_range(0, 99);
                if (roll < 55) cnt = COUNT_W'($urandom_range(1, 8));
                else if (roll < 75) cnt = COUNT_W'($urandom_range(9, MAX_FRAMES));
                else if (roll < 83) cnt = '0;
                else if (roll < 93) cnt = COUNT_W'($urandom_range(MAX_FRAMES + 1, 511));
                else cnt = COUNT_W'(MAX_FRAMES);
            end
            default:
                ;
        endcase
        send_cmd(req, elapsed, tgt, frm, cnt, per);
    endtask

    initial
    begin
        int phase;
        int k;
        // Hold reset, then release on a falling edge.
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats under the reset geometry: timing edges, table
        // extremes, same-state set, oversized frame, queued switch,
        // saturation and the unused request codes.
        send_cmd(REQ_LOAD, '0, 4'd0, '0, 9'd4, 32'h0001_0000);
        send_cmd(REQ_TICK, '0, '0, '0, '0, '0);
        send_cmd(REQ_TICK, 32'h0001_0000, '0, '0, '0, '0);  // equal to period: hold
        send_cmd(REQ_TICK, 32'h0000_0001, '0, '0, '0, '0);  // just past: advance
        send_cmd(REQ_TICK, 32'h0003_0000, '0, '0, '0, '0);  // several steps, wrap
        send_cmd(REQ_LOAD, '0, 4'd1, '0, 9'd0, 32'h0000_0000);
        send_cmd(REQ_LOAD, '0, 4'd2, '0, 9'd511, TIME_MAX);
        send_cmd(REQ_LOAD, '0, 4'd15, '0, 9'd256, 32'h0000_0001);
        send_cmd(REQ_SET_FRAME, '0, '0, 8'd200, '0, '0);
        send_cmd(REQ_SET_STATE, '0, 4'd0, '0, '0, '0);      // same state keeps frame
        send_cmd(REQ_TICK, '0, '0, '0, '0, '0);             // frame folds into count
        send_cmd(REQ_QUEUE, '0, 4'd15, '0, '0, '0);
        send_cmd(REQ_TICK, 32'h0004_0000, '0, '0, '0, '0);
        send_cmd(REQ_SET_KEEP, '0, 4'd1, '0, '0, '0);
        send_cmd(REQ_TICK, TIME_MAX, '0, '0, '0, '0);       // zero period, saturate
        send_cmd(REQ_TICK, TIME_MAX, '0, '0, '0, '0);
        send_cmd(REQ_SET_STATE, '0, 4'd2, '0, '0, '0);
        send_cmd(REQ_TICK, TIME_MAX, '0, '0, '0, '0);       // time equals max period
        send_cmd(REQ_TICK, 32'h0000_0001, '0, '0, '0, '0);
        send_cmd(REQ_RSVD0, $urandom, 4'hF, 8'hFF, 9'h1FF, $urandom);
        send_cmd(REQ_RSVD1, $urandom, 4'hF, 8'hFF, 9'h1FF, $urandom);
        send_cmd(REQ_SET_FRAME, '0, '0, 8'd255, '0, '0);
        send_cmd(REQ_TICK, '0, '0, '0, '0, '0);
        send_cmd(REQ_SET_STATE, '0, 4'd0, '0, '0, '0);
        send_cmd(REQ_QUEUE, '0, 4'd2, '0, '0, '0);
        send_cmd(REQ_TICK, 32'h0005_0000, '0, '0, '0, '0);  // wrap lands the switch
        drain_results();

        // Random phases: idling receiver first, then idling sender, then
        // neither. Each phase gets its own geometry, extremes included.
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 2)
            begin
                src_idle_pct = 34;
                dst_idle_pct = 53;
            end
            else if (phase < 4)
            begin
                src_idle_pct = 53;
                dst_idle_pct = 34;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            case (phase)
                0: write_config(12'd4095, 12'd4095, 1'b0);
                1: write_config(12'd1, 12'd1, 1'b1);
                2: write_config(DIM_W'($urandom_range(1, 4095)),
                                DIM_W'($urandom_range(1, 4095)), 1'b0);
                3: write_config(12'd4095, 12'd1, 1'b1);
                4: write_config(12'd1, 12'd4095, 1'b0);
                default: write_config(DIM_W'($urandom_range(1, 4095)),
                                      DIM_W'($urandom_range(1, 4095)), 1'b1);
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                send_random_cmd();
                // Now and then let the pipeline run dry mid-phase.
                if ($urandom_range(0, 99) == 0) drain_results();
            end
            drain_results();
        end

        // Watch for stray result beats once everything has been scored.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && positions_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/spranim_pkg.sv
rtl/spranim_ram.sv
rtl/spranim_div.sv
rtl/spranim_core.sv
rtl/sprite_animation_sequencer_top.sv
rtl/spranim_chk.sv
tb/sprite_animation_sequencer_checker.sv
tb/tb.sv
